// ===== hdl/kle_pkg.sv =====
// ----------------------------------------------------------------------------
// kle_pkg
// Shared constants and types for the keystroke line editor.
// ----------------------------------------------------------------------------
package kle_pkg;

  localparam int LINE_DEPTH_DEF = 64;
  localparam int KEY_W          = 8;

  localparam logic [KEY_W-1:0] KEY_BACKSPACE = 8'h2D;
  localparam logic [KEY_W-1:0] KEY_LEFT      = 8'h3C;
  localparam logic [KEY_W-1:0] KEY_RIGHT     = 8'h3E;

  typedef struct packed {
    logic [KEY_W-1:0] char_out;
    logic             char_valid;
    logic             last;
    logic             overflowed;
  } result_t;

endpackage

// ===== hdl/kle_key_if.sv =====
// ----------------------------------------------------------------------------
// kle_key_if
// Keystroke request channel: valid/ready with key code and end-of-line flag.
// ----------------------------------------------------------------------------
interface kle_key_if;
  logic                     valid;
  logic                     ready;
  logic [kle_pkg::KEY_W-1:0] key_code;
  logic                     end_of_line;

  modport source (output valid, output key_code, output end_of_line, input ready);
  modport sink   (input valid, input key_code, input end_of_line, output ready);
endinterface

// ===== hdl/kle_char_if.sv =====
// ----------------------------------------------------------------------------
// kle_char_if
// Line readout channel: valid/ready with one character and its flags.
// ----------------------------------------------------------------------------
interface kle_char_if;
  logic                     valid;
  logic                     ready;
  logic [kle_pkg::KEY_W-1:0] char_out;
  logic                     char_valid;
  logic                     last;
  logic                     overflowed;

  modport source (output valid, output char_out, output char_valid, output last,
                  output overflowed, input ready);
  modport sink   (input valid, input char_out, input char_valid, input last,
                  input overflowed, output ready);
endinterface

// ===== hdl/kle_line_mem.sv =====
// ----------------------------------------------------------------------------
// kle_line_mem
// Gap buffer storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kle_line_mem #(
  parameter int LINE_DEPTH = kle_pkg::LINE_DEPTH_DEF,
  parameter int AW         = $clog2(LINE_DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [kle_pkg::KEY_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [kle_pkg::KEY_W-1:0] rd_data
);

  logic [kle_pkg::KEY_W-1:0] mem [LINE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/kle_out_stage.sv =====
// ----------------------------------------------------------------------------
// kle_out_stage
// Output register for readout requests; frees itself as the sink takes one.
// ----------------------------------------------------------------------------
module kle_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  kle_pkg::result_t  load_data,
  output logic              free,
  kle_char_if.source        out_char
);

  logic             valid_r;
  logic             valid_nxt;
  kle_pkg::result_t data_r;

  assign free = !valid_r || out_char.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_char.ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_char.valid      = valid_r;
  assign out_char.char_out   = data_r.char_out;
  assign out_char.char_valid = data_r.char_valid;
  assign out_char.last       = data_r.last;
  assign out_char.overflowed = data_r.overflowed;

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("readout loaded over a pending request");

endmodule

// ===== hdl/keystroke_line_editor_unit.sv =====
// ----------------------------------------------------------------------------
// keystroke_line_editor_unit
// Gap buffer line editor: edits the line per keystroke, streams it out on
// end of line.
//
//   channel   | dir | payload                                  | handshake
//   ----------+-----+------------------------------------------+------------
//   in_key    | in  | key_code[7:0], end_of_line               | valid/ready
//   out_char  | out | char_out[7:0], char_valid, last, overflowed | valid/ready
//
// Insert, backspace and no-op keys finish when accepted; cursor moves read the line
// memory, then write it in S_MOVE. End of line goes through S_EOL, then reads each
// character in S_RD and hands it out in S_CAP, one at a time over the single read port.
// Reset (rst_n, synchronous) clears counts, flag and control; memory keeps
// its contents. in_key.ready is high only between keystrokes; a stalled
// out_char holds the readout in place.
// ----------------------------------------------------------------------------
module keystroke_line_editor_unit #(
  parameter int LINE_DEPTH = kle_pkg::LINE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  kle_key_if.sink     in_key,
  kle_char_if.source  out_char
);

  localparam int AW = $clog2(LINE_DEPTH);
  localparam int CW = $clog2(LINE_DEPTH + 1);
  localparam int EW = CW + 1;
  localparam logic [EW-1:0] DEPTH_E = EW'(LINE_DEPTH);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOVE = 5'b00010,
    S_EOL  = 5'b00100,
    S_RD   = 5'b01000,
    S_CAP  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   left_r, left_nxt;
  logic [CW-1:0]   right_r, right_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            ovf_r, ovf_nxt;
  logic            eol_r, eol_nxt;
  logic            dir_r, dir_nxt;
  logic [AW-1:0]   dst_r, dst_nxt;

  logic                      wr_en, rd_en;
  logic [AW-1:0]             wr_addr, rd_addr;
  logic [kle_pkg::KEY_W-1:0] wr_data, rd_data;

  logic              load, free;
  kle_pkg::result_t  load_data;

  logic [EW-1:0] left_e, right_e, idx_e, total_e;
  logic          accept, line_full, last_char;
  state_t        after_edit;

  assign left_e    = EW'(left_r);
  assign right_e   = EW'(right_r);
  assign idx_e     = EW'(idx_r);
  assign total_e   = left_e + right_e;
  assign line_full = (total_e == DEPTH_E);
  assign last_char = ((idx_e + EW'(1)) == total_e);

  assign in_key.ready = (state_r == S_IDLE);
  assign accept       = in_key.valid && in_key.ready;

  always_comb begin
    state_nxt  = state_r;
    left_nxt   = left_r;
    right_nxt  = right_r;
    idx_nxt    = idx_r;
    ovf_nxt    = ovf_r;
    eol_nxt    = eol_r;
    dir_nxt    = dir_r;
    dst_nxt    = dst_r;
    wr_en      = 1'b0;
    wr_addr    = AW'(left_r);
    wr_data    = in_key.key_code;
    rd_en      = 1'b0;
    rd_addr    = AW'(left_e - EW'(1));
    load       = 1'b0;
    load_data  = '{char_out: rd_data, char_valid: 1'b1, last: last_char,
                   overflowed: ovf_r};
    after_edit = in_key.end_of_line ? S_EOL : S_IDLE;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          eol_nxt   = in_key.end_of_line;
          state_nxt = after_edit;
          case (in_key.key_code)
            kle_pkg::KEY_BACKSPACE: begin
              if (left_r != '0) begin
                left_nxt = left_r - CW'(1);
              end
            end
            kle_pkg::KEY_LEFT: begin
              if (left_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(left_e - EW'(1));
                dst_nxt   = AW'(DEPTH_E - right_e - EW'(1));
                dir_nxt   = 1'b0;
                state_nxt = S_MOVE;
              end
            end
            kle_pkg::KEY_RIGHT: begin
              if (right_r != '0) begin
                rd_en     = 1'b1;
                rd_addr   = AW'(DEPTH_E - right_e);
                dst_nxt   = AW'(left_r);
                dir_nxt   = 1'b1;
                state_nxt = S_MOVE;
              end
            end
            default: begin
              if (!line_full) begin
                wr_en    = 1'b1;
                wr_addr  = AW'(left_r);
                wr_data  = in_key.key_code;
                left_nxt = left_r + CW'(1);
              end else begin
                ovf_nxt = 1'b1;
              end
            end
          endcase
        end
      end
      S_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = dst_r;
        wr_data = rd_data;
        if (dir_r) begin
          left_nxt  = left_r + CW'(1);
          right_nxt = right_r - CW'(1);
        end else begin
          left_nxt  = left_r - CW'(1);
          right_nxt = right_r + CW'(1);
        end
        state_nxt = eol_r ? S_EOL : S_IDLE;
      end
      S_EOL: begin
        if (total_e == '0) begin
          if (free) begin
            load      = 1'b1;
            load_data = '{char_out: '0, char_valid: 1'b0, last: 1'b1,
                          overflowed: ovf_r};
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end
        end else begin
          idx_nxt   = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        rd_en = 1'b1;
        if (idx_e < left_e) begin
          rd_addr = AW'(idx_r);
        end else begin
          rd_addr = AW'(idx_e + (DEPTH_E - total_e));
        end
        state_nxt = S_CAP;
      end
      S_CAP: begin
        if (free) begin
          load = 1'b1;
          if (last_char) begin
            left_nxt  = '0;
            right_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + CW'(1);
            state_nxt = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      left_r  <= '0;
      right_r <= '0;
      ovf_r   <= 1'b0;
      eol_r   <= 1'b0;
      idx_r   <= '0;
      dir_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      left_r  <= left_nxt;
      right_r <= right_nxt;
      ovf_r   <= ovf_nxt;
      eol_r   <= eol_nxt;
      idx_r   <= idx_nxt;
      dir_r   <= dir_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r <= dst_nxt;
  end

  kle_line_mem #(
    .LINE_DEPTH (LINE_DEPTH),
    .AW         (AW)
  ) u_line_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  kle_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .load_data (load_data),
    .free      (free),
    .out_char  (out_char)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_e <= DEPTH_E)
    else $error("gap buffer counts exceed line depth");

  a_load_states: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> (state_r == S_CAP || state_r == S_EOL))
    else $error("readout request outside readout states");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (load && load_data.last) |=>
      (state_r == S_IDLE && left_r == '0 && right_r == '0 && !ovf_r))
    else $error("line not cleared after final readout request");

  a_move_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |-> ($past(state_r) == S_IDLE))
    else $error("cursor move not started from a keystroke");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Testbench for keystroke_line_editor_unit. A short table of keystrokes covers
// the line edges, the empty line and the extreme bytes. A line that fills the
// store and then overflows follows, and then random lines mixed with loose
// keystrokes. Every readout character is checked against a gap buffer
// predictor kept in the bench. The key sender works in bursts with gaps, and
// the readout side stalls on patterns of its own. Once, the readout side holds
// off for a long stretch while keystrokes keep coming.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH         = kle_pkg::LINE_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 145;
  localparam int STALL_LIMIT   = 2000;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_AFTER    = 30;
  localparam int DRAIN_CYCLES  = 150;

  typedef struct {
    logic [kle_pkg::KEY_W-1:0] key;
    logic                      eol;
    bit                        typed;
    kle_pkg::result_t          want;
  } script_step_t;

  logic clk;
  logic rst_n;

  kle_key_if  key_bus ();
  kle_char_if char_bus ();

  keystroke_line_editor_unit #(
    .LINE_DEPTH (DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_key   (key_bus),
    .out_char (char_bus)
  );

  // Gap buffer shadow of the line
  logic [kle_pkg::KEY_W-1:0] line_mem [DEPTH];
  int                        n_left;
  int                        n_right;
  logic                      line_ovf;

  kle_pkg::result_t pending_chars [$];
  script_step_t     key_script [$];
  int               mismatch_count;
  int               chars_checked;
  int               keys_sent;
  int               burst_left;
  int               quiet_cycles;
  bit               long_hold_done;

  initial begin
    clk = 1'b0;
  end

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic edit_and_predict(input logic [kle_pkg::KEY_W-1:0] code, input logic eol);
    int               total;
    kle_pkg::result_t r;
    case (code)
      kle_pkg::KEY_BACKSPACE: begin
        if (n_left > 0) n_left--;
      end
      kle_pkg::KEY_LEFT: begin
        if (n_left > 0) begin
          line_mem[DEPTH - n_right - 1] = line_mem[n_left - 1];
          n_left--;
          n_right++;
        end
      end
      kle_pkg::KEY_RIGHT: begin
        if (n_right > 0) begin
          line_mem[n_left] = line_mem[DEPTH - n_right];
          n_left++;
          n_right--;
        end
      end
      default: begin
        if (n_left + n_right < DEPTH) begin
          line_mem[n_left] = code;
          n_left++;
        end else begin
          line_ovf = 1'b1;
        end
      end
    endcase
    if (!eol) return;
    total = n_left + n_right;
    if (total == 0) begin
      r = '{char_out: '0, char_valid: 1'b0, last: 1'b1, overflowed: line_ovf};
      pending_chars.push_back(r);
    end else begin
      for (int idx = 0; idx < total; idx++) begin
        r.char_out   = (idx < n_left) ? line_mem[idx]
                                      : line_mem[DEPTH - n_right + (idx - n_left)];
        r.char_valid = 1'b1;
        r.last       = (idx == total - 1);
        r.overflowed = line_ovf;
        pending_chars.push_back(r);
      end
    end
    n_left   = 0;
    n_right  = 0;
    line_ovf = 1'b0;
  endtask

  task automatic send_key(input logic [kle_pkg::KEY_W-1:0] code, input logic eol);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        key_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    key_bus.valid       <= 1'b1;
    key_bus.key_code    <= code;
    key_bus.end_of_line <= eol;
    do @(posedge clk); while (!key_bus.ready);
    edit_and_predict(code, eol);
    keys_sent++;
  endtask

  task automatic add_step(input logic [kle_pkg::KEY_W-1:0] key, input logic eol,
                          input bit typed, input logic cv,
                          input logic [kle_pkg::KEY_W-1:0] ch);
    script_step_t s;
    s.key   = key;
    s.eol   = eol;
    s.typed = typed;
    s.want  = '{char_out: ch, char_valid: cv, last: 1'b1, overflowed: 1'b0};
    key_script.push_back(s);
  endtask

  function automatic logic [kle_pkg::KEY_W-1:0] plain_byte();
    logic [kle_pkg::KEY_W-1:0] b;
    do b = kle_pkg::KEY_W'($urandom_range(0, 255));
    while (b == kle_pkg::KEY_BACKSPACE || b == kle_pkg::KEY_LEFT || b == kle_pkg::KEY_RIGHT);
    return b;
  endfunction

  function automatic logic [kle_pkg::KEY_W-1:0] random_key(input int edit_pct);
    if ($urandom_range(0, 99) < edit_pct) begin
      case ($urandom_range(0, 2))
        0:       return kle_pkg::KEY_BACKSPACE;
        1:       return kle_pkg::KEY_LEFT;
        default: return kle_pkg::KEY_RIGHT;
      endcase
    end
    return kle_pkg::KEY_W'($urandom_range(0, 255));
  endfunction

  task automatic flag_mismatch(input string what, input kle_pkg::result_t want,
                               input kle_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("MISMATCH %s: expected %02h/%b/%b/%b got %02h/%b/%b/%b",
               what, want.char_out, want.char_valid, want.last, want.overflowed,
               got.char_out, got.char_valid, got.last, got.overflowed);
  endtask

  // Readout checker
  always @(posedge clk) begin
    kle_pkg::result_t got;
    kle_pkg::result_t want;
    if (rst_n && char_bus.valid && char_bus.ready) begin
      got.char_out   = char_bus.char_out;
      got.char_valid = char_bus.char_valid;
      got.last       = char_bus.last;
      got.overflowed = char_bus.overflowed;
      if (pending_chars.size() == 0) begin
        flag_mismatch("unexpected result", '0, got);
      end else begin
        want = pending_chars.pop_front();
        if (got.char_out !== want.char_out || got.char_valid !== want.char_valid ||
            got.last !== want.last || got.overflowed !== want.overflowed)
          flag_mismatch($sformatf("result %0d", chars_checked), want, got);
      end
      chars_checked++;
    end
  end

  // Watchdog on handshake progress
  always @(posedge clk) begin
    if (!rst_n || (key_bus.valid && key_bus.ready) || (char_bus.valid && char_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Readout side stall patterns
  initial begin
    int   mode;
    int   phase;
    logic rdy;
    mode = 0;
    phase = 0;
    char_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        char_bus.ready <= 1'b0;
      end else if (!long_hold_done && chars_checked >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        char_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (phase == 0) begin
          mode  = $urandom_range(0, 3);
          phase = 32;
        end
        phase--;
        case (mode)
          0:       rdy = 1'b1;
          1:       rdy = 1'($urandom_range(0, 1));
          2:       rdy = (phase % 4 == 0);
          default: rdy = phase[0];
        endcase
        char_bus.ready <= rdy;
      end
    end
  end

  initial begin
    int start;
    int len;
    n_left              = 0;
    n_right             = 0;
    line_ovf            = 1'b0;
    mismatch_count      = 0;
    chars_checked       = 0;
    keys_sent           = 0;
    burst_left          = 0;
    quiet_cycles        = 0;
    long_hold_done      = 1'b0;
    for (int i = 0; i < DEPTH; i++) line_mem[i] = '0;
    rst_n               = 1'b0;
    key_bus.valid       = 1'b0;
    key_bus.key_code    = '0;
    key_bus.end_of_line = 1'b0;

    add_step(kle_pkg::KEY_BACKSPACE, 1'b1, 1'b1, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b1, 1'b1, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_RIGHT,     1'b1, 1'b1, 1'b0, 8'h00);
    add_step(8'h00,                  1'b1, 1'b1, 1'b1, 8'h00);
    add_step(8'hFF,                  1'b1, 1'b1, 1'b1, 8'hFF);
    add_step(8'h61,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(8'h62,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b0, 1'b0, 1'b0, 8'h00);
    add_step(8'h63,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_RIGHT,     1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_RIGHT,     1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_RIGHT,     1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_BACKSPACE, 1'b0, 1'b0, 1'b0, 8'h00);
    add_step(8'h64,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_BACKSPACE, 1'b1, 1'b0, 1'b0, 8'h00);
    add_step(8'h78,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_BACKSPACE, 1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_BACKSPACE, 1'b0, 1'b0, 1'b0, 8'h00);
    add_step(8'h55,                  1'b1, 1'b1, 1'b1, 8'h55);
    add_step(8'hAA,                  1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_LEFT,      1'b0, 1'b0, 1'b0, 8'h00);
    add_step(kle_pkg::KEY_BACKSPACE, 1'b1, 1'b1, 1'b1, 8'hAA);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_script[i]) begin
      send_key(key_script[i].key, key_script[i].eol);
      if (key_script[i].typed) begin
        void'(pending_chars.pop_back());
        pending_chars.push_back(key_script[i].want);
      end
    end

    // Fill the store, park one character right of the cursor, overflow, then delete
    start = keys_sent;
    for (int i = 0; i < DEPTH; i++) send_key(plain_byte(), 1'b0);
    send_key(kle_pkg::KEY_LEFT, 1'b0);
    send_key(plain_byte(), 1'b0);
    send_key(kle_pkg::KEY_BACKSPACE, 1'b1);

    while (keys_sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 9) == 0) begin
        len = $urandom_range(3, 10);
        for (int j = 0; j < len; j++)
          send_key(random_key(50), $urandom_range(0, 3) == 0);
      end else begin
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 14);
        for (int j = 0; j < len; j++)
          send_key(random_key(30), j == len - 1);
      end
    end
    key_bus.valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
